// ===== rtl/core/etqso_pkg.sv =====
// Shared types and constants for the elevator target queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package etqso_pkg;

  // Default queue size and the widths that follow from it
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned COUNT_W_DEF     = $clog2(QUEUE_DEPTH_DEF + 1);

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned FLOOR_W = 4;
  localparam int unsigned DIR_W   = 2;

  // Minimum reported for an empty queue; also the ceiling of the minimum search
  localparam logic [FLOOR_W-1:0] EMPTY_MIN = 4'd14;

  // Travel direction codes; the remaining codes leave the order alone
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REORDER = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // take the request, apply push/pop/read
    logic sort_pass;  // run one odd-even compare-exchange pass
    logic scan_step;  // fold one entry into the max/min search
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_sort;  // offered request is a reorder with a sweeping direction
    logic pass_last;  // the current sort pass is the final one
    logic scan_end;   // max/min search has covered every entry
  } dp_status_t;

endpackage

// ===== rtl/core/etqso_if.sv =====
// Request and response channels of the elevator target queue.
// Depends on etqso_pkg for field widths.
interface etqso_req_if import etqso_pkg::*; #(
  parameter int unsigned COUNT_W = COUNT_W_DEF
) ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [FLOOR_W-1:0] floor_value;
  logic [FLOOR_W-1:0] current_floor;
  logic [DIR_W-1:0]   travel_direction;
  logic [COUNT_W-1:0] entry_index;

  modport source (
    output valid, operation, floor_value, current_floor, travel_direction, entry_index,
    input  ready
  );
  modport sink (
    input  valid, operation, floor_value, current_floor, travel_direction, entry_index,
    output ready
  );
endinterface

interface etqso_rsp_if import etqso_pkg::*; #(
  parameter int unsigned COUNT_W = COUNT_W_DEF
) ();
  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] value;
  logic [COUNT_W-1:0] count;
  logic [FLOOR_W-1:0] max_floor;
  logic [FLOOR_W-1:0] min_floor;
  logic               error;

  modport source (
    output valid, value, count, max_floor, min_floor, error,
    input  ready
  );
  modport sink (
    input  valid, value, count, max_floor, min_floor, error,
    output ready
  );
endinterface

// ===== rtl/core/etqso_ctrl.sv =====
// Sequencing controller for the elevator target queue.
// Depends on etqso_pkg for the command and status structs.
module etqso_ctrl import etqso_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Handshake follows the state register
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  // Next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = status.need_sort ? S_SORT : S_SCAN;
        end
      end
      S_SORT: begin
        cmd.sort_pass = 1'b1;
        if (status.pass_last) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_end) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/etqso_datapath.sv =====
// Floor store, odd-even sorter and max/min search of the elevator target queue.
// Depends on etqso_pkg; driven by etqso_ctrl through ctl_cmd_t.
module etqso_datapath import etqso_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output dp_status_t         status,
  input  logic [OP_W-1:0]    operation,
  input  logic [FLOOR_W-1:0] floor_value,
  input  logic [FLOOR_W-1:0] current_floor,
  input  logic [DIR_W-1:0]   travel_direction,
  input  logic [COUNT_W-1:0] entry_index,
  output logic [FLOOR_W-1:0] value,
  output logic [COUNT_W-1:0] count,
  output logic [FLOOR_W-1:0] max_floor,
  output logic [FLOOR_W-1:0] min_floor,
  output logic               error
);

  localparam int unsigned ADDR_W = $clog2(QUEUE_DEPTH);

  // Service-order key: the first group sorts ahead, then by the remaining bits
  function automatic logic [FLOOR_W:0] sort_key(input logic [FLOOR_W-1:0] f,
                                                input logic [FLOOR_W-1:0] c,
                                                input logic               up);
    logic [FLOOR_W:0] k;
    if (up) begin
      k = (f > c) ? {1'b0, f} : {1'b1, ~f};
    end else begin
      k = (f < c) ? {1'b0, ~f} : {1'b1, f};
    end
    return k;
  endfunction

  logic [FLOOR_W-1:0] store      [QUEUE_DEPTH];
  logic [FLOOR_W-1:0] store_next [QUEUE_DEPTH];
  logic [FLOOR_W:0]   key        [QUEUE_DEPTH];
  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] entry_count_next;
  logic [FLOOR_W-1:0] cur_floor;
  logic               dir_up;
  logic [ADDR_W-1:0]  pass_cnt;
  logic [COUNT_W-1:0] scan_ptr;
  logic [FLOOR_W-1:0] max_acc;
  logic [FLOOR_W-1:0] min_acc;
  logic [FLOOR_W-1:0] result_value;
  logic               result_error;
  logic [FLOOR_W-1:0] load_value;
  logic               load_error;
  logic [COUNT_W-1:0] idx_m1;
  logic [ADDR_W-1:0]  rd_addr;
  logic [FLOOR_W-1:0] rd_data;
  logic               full;
  logic               empty;
  logic               read_bad;
  op_t                op_in;

  assign op_in    = op_t'(operation);
  assign full     = (entry_count == COUNT_W'(QUEUE_DEPTH));
  assign empty    = (entry_count == '0);
  assign read_bad = (entry_index == '0) || (entry_index > entry_count);
  assign idx_m1   = entry_index - 1'b1;

  // Single read port: requested index on load, search pointer otherwise
  assign rd_addr = cmd.load ? idx_m1[ADDR_W-1:0] : scan_ptr[ADDR_W-1:0];
  assign rd_data = store[rd_addr];

  // Status back to the controller
  assign status.need_sort = (op_in == OP_REORDER) &&
                            ((travel_direction == DIR_UP) || (travel_direction == DIR_DOWN));
  assign status.pass_last = (pass_cnt == ADDR_W'(QUEUE_DEPTH - 1));
  assign status.scan_end  = (scan_ptr >= entry_count);

  // Result fields
  assign value     = result_value;
  assign count     = entry_count;
  assign max_floor = max_acc;
  assign min_floor = min_acc;
  assign error     = result_error;

  // Per-entry sort keys
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      key[i] = sort_key(store[i], cur_floor, dir_up);
    end
  end

  // Result of the request itself
  always_comb begin
    load_value = '0;
    load_error = 1'b0;
    case (op_in)
      OP_PUSH: begin
        load_error = full;
      end
      OP_POP: begin
        load_error = empty;
        load_value = empty ? '0 : store[0];
      end
      OP_REORDER: begin
        load_error = 1'b0;
      end
      OP_READ: begin
        load_error = read_bad;
        load_value = read_bad ? '0 : rd_data;
      end
      default: begin
        load_error = 1'b0;
      end
    endcase
  end

  // Store update: append, shift out the head, or one compare-exchange pass
  always_comb begin
    store_next       = store;
    entry_count_next = entry_count;
    if (cmd.load) begin
      case (op_in)
        OP_PUSH: begin
          if (!full) begin
            store_next[entry_count[ADDR_W-1:0]] = floor_value;
            entry_count_next = entry_count + 1'b1;
          end
        end
        OP_POP: begin
          if (!empty) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              store_next[i] = store[i + 1];
            end
            entry_count_next = entry_count - 1'b1;
          end
        end
        default: begin
          entry_count_next = entry_count;
        end
      endcase
    end else if (cmd.sort_pass) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if ((i[0] == pass_cnt[0]) && (COUNT_W'(i + 1) < entry_count) &&
            (key[i] > key[i + 1])) begin
          store_next[i]     = store[i + 1];
          store_next[i + 1] = store[i];
        end
      end
    end
  end

  // Hold the floor store
  always_ff @(posedge clk) begin
    store <= store_next;
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  // Latch the request, advance the sorter and the max/min search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_floor    <= current_floor;
      dir_up       <= (travel_direction == DIR_UP);
      pass_cnt     <= '0;
      scan_ptr     <= '0;
      max_acc      <= '0;
      min_acc      <= EMPTY_MIN;
      result_value <= load_value;
      result_error <= load_error;
    end else begin
      if (cmd.sort_pass) begin
        pass_cnt <= pass_cnt + 1'b1;
      end
      if (cmd.scan_step) begin
        if (rd_data > max_acc) begin
          max_acc <= rd_data;
        end
        if (rd_data < min_acc) begin
          min_acc <= rd_data;
        end
        scan_ptr <= scan_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/elevator_target_queue_scan_order.sv =====
// Elevator target queue with sweep ordering. Each request (push, pop, read at a
// 1-based index, or reorder for the car's floor and direction) gives one response
// with the value, the count, and the largest and smallest queued floor. After the
// request is accepted, the max/min search walks the floors queued afterwards one entry
// per cycle through its single read port and then sees its end before the response
// is offered. A reorder going up or down first runs QUEUE_DEPTH odd-even
// compare-exchange passes. One request is in flight at a time; the next is taken in
// the cycle after the response is collected.
// Depends on etqso_pkg, etqso_if, etqso_ctrl and etqso_datapath.
module elevator_target_queue_scan_order import etqso_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  etqso_req_if.sink   req,
  etqso_rsp_if.source rsp
);

  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       req_ready;
  logic       rsp_valid;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  // Sequence each request
  etqso_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Store, sorter and result registers
  etqso_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_W     (COUNT_W)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .operation        (req.operation),
    .floor_value      (req.floor_value),
    .current_floor    (req.current_floor),
    .travel_direction (req.travel_direction),
    .entry_index      (req.entry_index),
    .value            (rsp.value),
    .count            (rsp.count),
    .max_floor        (rsp.max_floor),
    .min_floor        (rsp.min_floor),
    .error            (rsp.error)
  );

endmodule
